/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL. Empty bodies for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_ALWAYS(label, clk, rst, cond, msg)
`endif
`endif

/* rtl/core/mhpq_pkg.sv */
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared constants and codes for the max-heap priority queue core.
// ----------------------------------------------------------------------------
package mhpq_pkg;

   localparam int CAPACITY    = 16;
   localparam int MAX_RESULTS = 16;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int RES_W       = $clog2(MAX_RESULTS + 1);
   localparam int ENTRY_W     = 26;

   localparam logic [2:0] THRESHOLD_RESET = 3'd4;

   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_EXTRACT = 2'd1;
   localparam logic [1:0] OP_DRAIN   = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef logic [ENTRY_W-1:0] entry_type;

   function automatic logic [2:0] key_of(input entry_type e);
      key_of = e[2:0];
   endfunction

endpackage

/* rtl/core/max_heap_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// max_heap_priority_queue_core
// Array-backed binary max-heap of records kept in one entry RAM.
// ----------------------------------------------------------------------------
//  channel | ports                              | direction
//  req     | req_valid/req_ready + record, op   | in
//  rsp     | rsp_valid/rsp_ready + status, rec  | out
//  csr     | csr_wr_en/csr_wr_data (threshold)  | in
//
// An insert's response is registered and shows in the cycle after the request.
// An extract runs two full bottom-up rebuilds; each sift level that moves steps
// through S_SIFT0 to S_SIFT4 on the single read port of the entry RAM (ending
// after S_SIFT3 where it stops, after S_SIFT0 at a leaf), plus the root swap
// S_SW0 to S_SW3. A drain adds the root check S_CK0, S_CK1 per record.
// Reset clears the count, the threshold (to 4) and the response valid flag;
// the RAM holds no reset state. One item is worked at a time; a drain beat
// that is not the last holds the sequencer until rsp_ready takes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module max_heap_priority_queue_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_patient_id,
   input  logic [6:0]  req_age,
   input  logic [2:0]  req_urgency,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_out_id,
   output logic [6:0]  rsp_out_age,
   output logic [2:0]  rsp_out_urgency,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data
);

   localparam int IW = mhpq_pkg::IDX_W;
   localparam int CW = mhpq_pkg::CNT_W;
   localparam int LW = mhpq_pkg::IDX_W + 2;

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SIFT0 = 4'd1;
   localparam logic [3:0] S_SIFT1 = 4'd2;
   localparam logic [3:0] S_SIFT2 = 4'd3;
   localparam logic [3:0] S_SIFT3 = 4'd4;
   localparam logic [3:0] S_SIFT4 = 4'd5;
   localparam logic [3:0] S_RB    = 4'd6;
   localparam logic [3:0] S_SW0   = 4'd7;
   localparam logic [3:0] S_SW1   = 4'd8;
   localparam logic [3:0] S_SW2   = 4'd9;
   localparam logic [3:0] S_SW3   = 4'd10;
   localparam logic [3:0] S_CK0   = 4'd11;
   localparam logic [3:0] S_CK1   = 4'd12;
   localparam logic [3:0] S_WAIT  = 4'd13;

   // which rebuild is running
   localparam logic [1:0] PH_EXT1   = 2'd0;
   localparam logic [1:0] PH_EXT2   = 2'd1;
   localparam logic [1:0] PH_DRAIN0 = 2'd2;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  op_ff, op_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic [IW-1:0] best_ff, best_in;
   mhpq_pkg::entry_type cur_ff, cur_in;
   mhpq_pkg::entry_type lv_ff, lv_in;
   mhpq_pkg::entry_type bestv_ff, bestv_in;
   mhpq_pkg::entry_type top_ff, top_in;
   logic [mhpq_pkg::RES_W-1:0] nres_ff, nres_in;
   logic [2:0]  thr_ff, thr_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   mhpq_pkg::entry_type rsp_rec_ff, rsp_rec_in;
   logic        rsp_last_ff, rsp_last_in;

   // entry RAM port
   logic        ram_we;
   logic [IW-1:0] ram_waddr, ram_raddr;
   mhpq_pkg::entry_type ram_wdata, ram_rdata;

   mhpq_ram #(
      .WIDTH (mhpq_pkg::ENTRY_W),
      .DEPTH (mhpq_pkg::CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // child positions of the node under sift
   logic [LW-1:0] l_w, r_w;
   logic          l_ok, r_ok;
   logic [CW-1:0] cnt_m1;
   logic          req_fire, cond_go;

   assign l_w    = {pos_ff, 1'b0} + LW'(1);
   assign r_w    = {pos_ff, 1'b0} + LW'(2);
   assign l_ok   = l_w < LW'(count_ff);
   assign r_ok   = r_w < LW'(count_ff);
   assign cnt_m1 = count_ff - CW'(1);

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;

   // keep draining: records left, root qualifies, beat budget not spent
   assign cond_go = (count_ff != '0)
                 && (mhpq_pkg::key_of(ram_rdata) >= thr_ff)
                 && (nres_ff < mhpq_pkg::RES_W'(mhpq_pkg::MAX_RESULTS));

   always_comb begin
      logic [IW-1:0] b;
      logic [2:0]    bk;
      mhpq_pkg::entry_type bv;
      logic [CW-1:0] rb_count;
      logic          rb_start;

      state_in      = state_ff;
      phase_in      = phase_ff;
      op_in         = op_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      best_in       = best_ff;
      cur_in        = cur_ff;
      lv_in         = lv_ff;
      bestv_in      = bestv_ff;
      top_in        = top_ff;
      nres_in       = nres_ff;
      thr_in        = csr_wr_en ? csr_wr_data : thr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_last_in   = rsp_last_ff;
      ram_we        = 1'b0;
      ram_waddr     = pos_ff;
      ram_wdata     = cur_ff;
      ram_raddr     = pos_ff;
      b             = pos_ff;
      bk            = mhpq_pkg::key_of(cur_ff);
      bv            = cur_ff;
      rb_count      = count_ff;
      rb_start      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in = req_operation;
               unique case (req_operation)
                  mhpq_pkg::OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     rsp_rec_in   = '0;
                     rsp_last_in  = 1'b1;
                     if (count_ff >= CW'(mhpq_pkg::CAPACITY)) begin
                        rsp_status_in = mhpq_pkg::STATUS_FULL;
                     end else begin
                        rsp_status_in = mhpq_pkg::STATUS_OK;
                        ram_we        = 1'b1;
                        ram_waddr     = count_ff[IW-1:0];
                        ram_wdata     = {req_patient_id, req_age, req_urgency};
                        count_in      = count_ff + CW'(1);
                     end
                  end
                  mhpq_pkg::OP_EXTRACT: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = mhpq_pkg::STATUS_EMPTY;
                        rsp_rec_in    = '0;
                        rsp_last_in   = 1'b1;
                     end else begin
                        phase_in = PH_EXT1;
                        rb_start = 1'b1;
                     end
                  end
                  mhpq_pkg::OP_DRAIN: begin
                     nres_in  = '0;
                     phase_in = PH_DRAIN0;
                     rb_start = 1'b1;
                  end
                  default: begin
                     // unused code: drop the beat
                  end
               endcase
            end
         end
         S_SIFT0: begin
            ram_raddr = pos_ff;
            state_in  = l_ok ? S_SIFT1 : S_RB;
         end
         S_SIFT1: begin
            cur_in    = ram_rdata;
            ram_raddr = l_w[IW-1:0];
            state_in  = S_SIFT2;
         end
         S_SIFT2: begin
            lv_in     = ram_rdata;
            ram_raddr = r_w[IW-1:0];
            state_in  = S_SIFT3;
         end
         S_SIFT3: begin
            if (bk < mhpq_pkg::key_of(lv_ff)) begin
               b  = l_w[IW-1:0];
               bk = mhpq_pkg::key_of(lv_ff);
               bv = lv_ff;
            end
            if (r_ok && (bk < mhpq_pkg::key_of(ram_rdata))) begin
               b  = r_w[IW-1:0];
               bv = ram_rdata;
            end
            if (b == pos_ff) begin
               state_in = S_RB;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = b;
               ram_wdata = cur_ff;
               best_in   = b;
               bestv_in  = bv;
               state_in  = S_SIFT4;
            end
         end
         S_SIFT4: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff;
            ram_wdata = bestv_ff;
            pos_in    = best_ff;
            state_in  = S_SIFT0;
         end
         S_RB: begin
            if (idx_ff == '0) begin
               unique case (phase_ff)
                  PH_EXT1: state_in = S_SW0;
                  PH_EXT2: begin
                     if (op_ff == mhpq_pkg::OP_EXTRACT) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = mhpq_pkg::STATUS_OK;
                        rsp_rec_in    = top_ff;
                        rsp_last_in   = 1'b1;
                        state_in      = S_IDLE;
                     end else begin
                        nres_in  = nres_ff + mhpq_pkg::RES_W'(1);
                        state_in = S_CK0;
                     end
                  end
                  default: state_in = S_CK0;
               endcase
            end else begin
               pos_in   = IW'(idx_ff - CW'(1));
               idx_in   = idx_ff - CW'(1);
               state_in = S_SIFT0;
            end
         end
         S_SW0: begin
            ram_raddr = '0;
            state_in  = S_SW1;
         end
         S_SW1: begin
            top_in    = ram_rdata;
            ram_raddr = cnt_m1[IW-1:0];
            state_in  = S_SW2;
         end
         S_SW2: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = ram_rdata;
            state_in  = S_SW3;
         end
         S_SW3: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_m1[IW-1:0];
            ram_wdata = top_ff;
            count_in  = cnt_m1;
            rb_count  = cnt_m1;
            phase_in  = PH_EXT2;
            rb_start  = 1'b1;
         end
         S_CK0: begin
            ram_raddr = '0;
            state_in  = S_CK1;
         end
         S_CK1: begin
            if (nres_ff != '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = mhpq_pkg::STATUS_OK;
               rsp_rec_in    = top_ff;
               rsp_last_in   = !cond_go;
               state_in      = cond_go ? S_WAIT : S_IDLE;
            end else if (cond_go) begin
               phase_in = PH_EXT1;
               rb_start = 1'b1;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = mhpq_pkg::STATUS_EMPTY;
               rsp_rec_in    = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_WAIT: begin
            // hold until the drain beat is taken, then extract the next one
            if (rsp_ready) begin
               phase_in = PH_EXT1;
               rb_start = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (rb_start) begin
         idx_in   = (rb_count < CW'(2)) ? '0 : (rb_count >> 1);
         state_in = S_RB;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         thr_ff       <= mhpq_pkg::THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff      <= phase_in;
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      best_ff       <= best_in;
      cur_ff        <= cur_in;
      lv_ff         <= lv_in;
      bestv_ff      <= bestv_in;
      top_ff        <= top_in;
      nres_ff       <= nres_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_id      = rsp_rec_ff[25:10];
   assign rsp_out_age     = rsp_rec_ff[9:3];
   assign rsp_out_urgency = rsp_rec_ff[2:0];
   assign rsp_last        = rsp_last_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(mhpq_pkg::CAPACITY), "count overflow")
   `ASSERT_IMPLIES(a_full_last, clock, reset, rsp_valid && rsp_status == mhpq_pkg::STATUS_FULL, rsp_last, "full beat not last")
   `ASSERT_IMPLIES(a_sift_pos, clock, reset, state_ff == S_SIFT3, LW'(pos_ff) < LW'(count_ff), "sift outside heap")
   `ASSERT_IMPLIES(a_wait_busy, clock, reset, state_ff == S_WAIT, rsp_valid_ff && !rsp_last_ff, "wait without open beat")

endmodule

/* rtl/core/mhpq_ram.sv */
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
